// File: src/crbm_pkg.sv
// Shared types, address constants and window mapping tables for the cartridge RAM bank mapper.
package crbm_pkg;

    // Store geometry: three RAM banks and one ROM bank in a single byte store
    localparam int STORE_DEPTH = 8192;
    localparam int STORE_AW    = 13;

    // Console address map
    localparam logic [12:0] ADDR_WIN_BIT_MASK = 13'h1000;
    localparam logic [12:0] ADDR_UPPER_BASE   = 13'h1800;
    localparam logic [12:0] ADDR_OFFSET_MASK  = 13'h07ff;
    localparam logic [12:0] ADDR_PAGE_MASK    = 13'h0f00;
    localparam logic [12:0] ADDR_MAP_CTRL     = 13'h1ff8;
    localparam logic [12:0] ADDR_LOAD_REQ     = 13'h1ff9;
    localparam logic [12:0] ADDR_LOW_PAGE_MAX = 13'h00ff;

    // Fields of the latched control byte
    localparam logic [7:0] CTRL_MAP_MASK = 8'h1c;
    localparam logic [7:0] CTRL_WE_MASK  = 8'h02;

    // Access counter: write slot and saturation point
    localparam logic [2:0] CNT_WRITE_SLOT = 3'd5;
    localparam logic [2:0] CNT_MAX        = 3'd6;

    // Input item kind
    typedef enum logic {
        OP_BUS  = 1'b0,
        OP_HOST = 1'b1
    } op_t;

    // Window codes
    typedef enum logic [1:0] {
        WIN_RAM0 = 2'd0,
        WIN_RAM1 = 2'd1,
        WIN_RAM2 = 2'd2,
        WIN_ROM  = 2'd3
    } win_t;

    // Lower window selected by the three-bit mapping code
    function automatic win_t map_lower(input logic [2:0] code);
        win_t w;
        unique case (code)
            3'd0:    w = WIN_RAM2;
            3'd1:    w = WIN_RAM0;
            3'd2:    w = WIN_RAM2;
            3'd3:    w = WIN_RAM0;
            3'd4:    w = WIN_RAM2;
            3'd5:    w = WIN_RAM1;
            3'd6:    w = WIN_RAM2;
            default: w = WIN_RAM1;
        endcase
        return w;
    endfunction

    // Upper window selected by the three-bit mapping code
    function automatic win_t map_upper(input logic [2:0] code);
        win_t w;
        unique case (code)
            3'd0:    w = WIN_ROM;
            3'd1:    w = WIN_ROM;
            3'd2:    w = WIN_RAM0;
            3'd3:    w = WIN_RAM2;
            3'd4:    w = WIN_ROM;
            3'd5:    w = WIN_ROM;
            3'd6:    w = WIN_RAM1;
            default: w = WIN_RAM2;
        endcase
        return w;
    endfunction

endpackage

// File: src/crbm_ram.sv
// Generic single-port synchronous RAM with registered read data.
module crbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write has priority; read data holds when the port is idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: src/cartridge_ram_bank_mapper.sv
// Top level of the cartridge RAM bank mapper: control registers, store access and result stage.
//
//   channel   dir   beat contents (low bit first)
//   s_axis    in    tuser: op | tdata: address[12:0], data_byte[20:13], zero pad [23:21]
//   m_axis    out   tdata: drive[0], read_data[8:1], load_request[9], load_id[17:10], pad
//
// One beat per clock while m_axis is ready; a result passes the read stage, then the result register.
// All control decisions are made when a beat is accepted; the single store port then does
// either the one read or the one write that the beat needs, so no forwarding is required.
// After reset the store is cleared, one entry per cycle, with s_axis_tready low until all 8192 are cleared.
// A stalled m_axis holds the result register, then the read stage, then s_axis_tready.
module cartridge_ram_bank_mapper #(
    parameter int BANK_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[12:0], data_byte[20:13], zero [23:21]
    input  logic [0:0]  s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // drive[0], read_data[8:1], load_request[9],
                                        // load_id[17:10], zero [23:18]
);

    localparam int AW = crbm_pkg::STORE_AW;

    // Window bases and multiples of the bank size for the offset reduction
    localparam logic [14:0] BANK_X1 = 15'(BANK_BYTES);
    localparam logic [14:0] BANK_X2 = 15'(BANK_BYTES * 2);
    localparam logic [14:0] BANK_X3 = 15'(BANK_BYTES * 3);
    localparam logic [14:0] BANK_X4 = 15'(BANK_BYTES * 4);

    // Input fields
    crbm_pkg::op_t op;
    logic [12:0]   address;
    logic [7:0]    data_byte;

    assign op        = crbm_pkg::op_t'(s_axis_tuser[0]);
    assign address   = s_axis_tdata[12:0];
    assign data_byte = s_axis_tdata[20:13];

    // Control state
    logic [7:0]      pending_reg,   pending_next;
    logic [2:0]      cnt_reg,       cnt_next;
    logic            wr_en_reg,     wr_en_next;
    crbm_pkg::win_t  lower_win_reg, lower_win_next;
    crbm_pkg::win_t  upper_win_reg, upper_win_next;
    logic [12:0]     prev_addr_reg, prev_addr_next;

    // Clearing pass
    logic            clr_active_reg;
    logic [AW-1:0]   clr_addr_reg;

    // Read stage
    logic            s1_valid_reg;
    logic            s1_drive_reg;
    logic            s1_use_ram_reg;
    logic [7:0]      s1_byte_reg;
    logic            s1_lreq_reg;
    logic [7:0]      s1_lid_reg;

    // Result register
    logic            out_valid_reg;
    logic [23:0]     out_data_reg;

    // Handshake
    logic            accept;
    logic            out_adv;
    logic            s1_adv;

    // Per-beat decode
    logic            in_window;
    logic            is_lower;
    crbm_pkg::win_t  win;
    logic            wslot;
    logic            is_lreq;
    logic            use_pending;
    logic            do_latch;
    logic            do_map;
    logic            do_write;
    logic [2:0]      map_code;
    logic [14:0]     off_a, off_b, off_c, off_d;
    logic [14:0]     win_base;
    logic [14:0]     idx_sum;
    logic [AW-1:0]   win_idx;

    // Store port
    logic            ram_en;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;

    logic [7:0]      out_byte;

    // Flow control
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_adv;
    assign s_axis_tready = !clr_active_reg && (!s1_valid_reg || out_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Offset inside a window: (address & 0x7ff) mod bank size, quotient is at most seven
    always_comb
    begin
        off_a = {4'd0, address[10:0]};
        off_b = (off_a >= BANK_X4) ? off_a - BANK_X4 : off_a;
        off_c = (off_b >= BANK_X2) ? off_b - BANK_X2 : off_b;
        off_d = (off_c >= BANK_X1) ? off_c - BANK_X1 : off_c;
    end

    // Beat decode
    always_comb
    begin
        in_window   = (address & crbm_pkg::ADDR_WIN_BIT_MASK) != 13'd0;
        is_lower    = address < crbm_pkg::ADDR_UPPER_BASE;
        win         = is_lower ? lower_win_reg : upper_win_reg;
        wslot       = wr_en_reg && (cnt_reg == crbm_pkg::CNT_WRITE_SLOT);
        is_lreq     = (address == crbm_pkg::ADDR_LOAD_REQ)
                      && (upper_win_reg == crbm_pkg::WIN_ROM)
                      && (prev_addr_reg <= crbm_pkg::ADDR_LOW_PAGE_MAX);
        use_pending = wslot && (is_lower || upper_win_reg != crbm_pkg::WIN_ROM);
        do_latch    = in_window && !is_lreq
                      && ((address & crbm_pkg::ADDR_PAGE_MASK) == 13'd0)
                      && (cnt_reg > crbm_pkg::CNT_WRITE_SLOT || !wr_en_reg);
        do_map      = in_window && !is_lreq && !do_latch
                      && (address == crbm_pkg::ADDR_MAP_CTRL);
        do_write    = in_window && !is_lreq && !do_latch && !do_map && use_pending;
        map_code    = 3'((pending_reg & crbm_pkg::CTRL_MAP_MASK) >> 2);
    end

    // Store index of the addressed window entry
    always_comb
    begin
        unique case (win)
            crbm_pkg::WIN_RAM0: win_base = 15'd0;
            crbm_pkg::WIN_RAM1: win_base = BANK_X1;
            crbm_pkg::WIN_RAM2: win_base = BANK_X2;
            default:            win_base = BANK_X3;
        endcase
        idx_sum = win_base + off_d;
        win_idx = idx_sum[AW-1:0];
    end

    // Next control state
    always_comb
    begin
        pending_next   = pending_reg;
        cnt_next       = cnt_reg;
        wr_en_next     = wr_en_reg;
        lower_win_next = lower_win_reg;
        upper_win_next = upper_win_reg;
        prev_addr_next = prev_addr_reg;
        if (accept && op == crbm_pkg::OP_BUS)
        begin
            priority if (do_latch)
            begin
                pending_next = address[7:0];
                cnt_next     = 3'd1;
            end
            else if (do_map)
            begin
                cnt_next       = crbm_pkg::CNT_MAX;
                wr_en_next     = (pending_reg & crbm_pkg::CTRL_WE_MASK) != 8'd0;
                lower_win_next = crbm_pkg::map_lower(map_code);
                upper_win_next = crbm_pkg::map_upper(map_code);
            end
            else if (cnt_reg < crbm_pkg::CNT_MAX)
            begin
                cnt_next = cnt_reg + 3'd1;
            end
            else
            begin
                cnt_next = cnt_reg;
            end
            prev_addr_next = address;
        end
    end

    // Store port: clearing pass, host write, window write or window read
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = win_idx;
        ram_wdata = pending_reg;
        priority if (clr_active_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = 8'd0;
        end
        else if (accept && op == crbm_pkg::OP_HOST)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = address;
            ram_wdata = data_byte;
        end
        else if (accept && do_write)
        begin
            ram_en = 1'b1;
            ram_we = 1'b1;
        end
        else if (accept && in_window && !is_lreq && !use_pending)
        begin
            ram_en = 1'b1;
        end
        else
        begin
            ram_en = 1'b0;
        end
    end

    crbm_ram #(
        .WIDTH (8),
        .DEPTH (crbm_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Control registers and clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 8'd0;
            cnt_reg        <= 3'd0;
            wr_en_reg      <= 1'b0;
            lower_win_reg  <= crbm_pkg::WIN_RAM0;
            upper_win_reg  <= crbm_pkg::WIN_ROM;
            prev_addr_reg  <= 13'd0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            cnt_reg       <= cnt_next;
            wr_en_reg     <= wr_en_next;
            lower_win_reg <= lower_win_next;
            upper_win_reg <= upper_win_next;
            prev_addr_reg <= prev_addr_next;
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_drive_reg   <= (op == crbm_pkg::OP_BUS) && in_window && !is_lreq;
            s1_use_ram_reg <= (op == crbm_pkg::OP_BUS) && in_window && !is_lreq
                              && !use_pending;
            s1_byte_reg    <= ((op == crbm_pkg::OP_BUS) && in_window && !is_lreq)
                              ? pending_reg : 8'd0;
            s1_lreq_reg    <= (op == crbm_pkg::OP_BUS) && is_lreq;
            s1_lid_reg     <= ((op == crbm_pkg::OP_BUS) && is_lreq) ? data_byte : 8'd0;
        end
    end

    // Result register payload
    assign out_byte = s1_use_ram_reg ? ram_rdata : s1_byte_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= {6'd0, s1_lid_reg, s1_lreq_reg, out_byte, s1_drive_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // No beat is taken while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_axis_tready)
        else $error("beat accepted during store clearing pass");

    // The access counter saturates at six
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= crbm_pkg::CNT_MAX)
        else $error("access counter out of range");

    // A load request cycle never drives the bus
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[9]))
        else $error("drive and load request in one result");

    // A byte is only presented when the bus is driven
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[8:1] == 8'd0))
        else $error("read data nonzero without drive");

endmodule
